### hw/rtl/source_line_classifier_defines.svh
// Assertion macros shared by the checker of the source line classifier.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef SOURCE_LINE_CLASSIFIER_DEFINES_SVH
`define SOURCE_LINE_CLASSIFIER_DEFINES_SVH

// Check a consequence in the cycle after the antecedent.
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequence in the same cycle as the antecedent.
`define SLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/slc_pkg.sv
// Shared types, constants and helpers of the source line classifier.
// Depends on nothing; used by every RTL module of the block.
package slc_pkg;

    localparam int MAX_MARKER_LEN = 6;
    localparam int COUNT_WIDTH    = 32;
    localparam int WIN_W          = 8 * MAX_MARKER_LEN;
    localparam int FILL_W         = $clog2(MAX_MARKER_LEN + 1);
    localparam int MARK_W         = 64;

    // Length caps: bytes held by each marker register, bounded by the window.
    localparam int LINE_CAP  = (MAX_MARKER_LEN < 2) ? MAX_MARKER_LEN : 2;
    localparam int OPEN_CAP  = (MAX_MARKER_LEN < 6) ? MAX_MARKER_LEN : 6;
    localparam int CLOSE_CAP = (MAX_MARKER_LEN < 4) ? MAX_MARKER_LEN : 4;

    localparam int OUT_CNT_W = 32;
    localparam int OUT_BITS  = 2 + 3 * OUT_CNT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [7:0] NEWLINE = 8'd10;

    // Register indexes (byte address divided by eight).
    localparam logic [2:0] REG_LINE_MARKER     = 3'd0;
    localparam logic [2:0] REG_LINE_MARKER_LEN = 3'd1;
    localparam logic [2:0] REG_BLOCK_OPEN      = 3'd2;
    localparam logic [2:0] REG_BLOCK_OPEN_LEN  = 3'd3;
    localparam logic [2:0] REG_BLOCK_CLOSE     = 3'd4;
    localparam logic [2:0] REG_BLOCK_CLOSE_LEN = 3'd5;

    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_CODE    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] line_marker;
        logic [1:0]  line_marker_len;
        logic [47:0] block_open;
        logic [2:0]  block_open_len;
        logic [31:0] block_close;
        logic [2:0]  block_close_len;
    } cfg_t;

    // Scan state carried between iterations of the scan unit.
    typedef struct packed {
        logic [FILL_W-1:0] skip;
        logic              blk_active;
        logic              saw_code;
        logic              line_hit;
    } scan_flags_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] code;
        logic [COUNT_WIDTH-1:0] comment;
        logic [COUNT_WIDTH-1:0] empty;
    } counts_t;

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

endpackage

### hw/rtl/slc_scan_unit.sv
// Shared scan step: tests the window head against the configured markers.
// Depends on slc_pkg.
module slc_scan_unit (
    input  logic [slc_pkg::WIN_W-1:0]  window_i,
    input  logic [slc_pkg::FILL_W-1:0] fill_i,
    input  slc_pkg::scan_flags_t       flags_i,
    input  slc_pkg::cfg_t              cfg_i,
    output logic [slc_pkg::WIN_W-1:0]  window_o,
    output logic [slc_pkg::FILL_W-1:0] fill_o,
    output slc_pkg::scan_flags_t       flags_o
);

    logic [slc_pkg::FILL_W-1:0] line_len;
    logic [slc_pkg::FILL_W-1:0] open_len;
    logic [slc_pkg::FILL_W-1:0] close_len;
    logic                       line_hit;
    logic                       open_hit;
    logic                       close_hit;

    function automatic logic [slc_pkg::FILL_W-1:0] clamp_len(logic [2:0] len, int cap);
        int n;
        n = int'(len);
        if (n > cap) begin
            n = cap;
        end
        return slc_pkg::FILL_W'(n);
    endfunction

    function automatic logic marker_at_head(logic [slc_pkg::WIN_W-1:0]  win,
                                            logic [slc_pkg::FILL_W-1:0] fill,
                                            logic [slc_pkg::MARK_W-1:0] mark,
                                            logic [slc_pkg::FILL_W-1:0] len);
        logic ok;
        ok = (len != '0) && (len <= fill);
        for (int k = 0; k < slc_pkg::MAX_MARKER_LEN; k++) begin
            if ((slc_pkg::FILL_W'(k) < len) && (win[8*k +: 8] != mark[8*k +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign line_len  = clamp_len({1'b0, cfg_i.line_marker_len}, slc_pkg::LINE_CAP);
    assign open_len  = clamp_len(cfg_i.block_open_len, slc_pkg::OPEN_CAP);
    assign close_len = clamp_len(cfg_i.block_close_len, slc_pkg::CLOSE_CAP);

    assign line_hit  = marker_at_head(window_i, fill_i,
                                      slc_pkg::MARK_W'(cfg_i.line_marker), line_len);
    assign open_hit  = marker_at_head(window_i, fill_i,
                                      slc_pkg::MARK_W'(cfg_i.block_open), open_len);
    assign close_hit = marker_at_head(window_i, fill_i,
                                      slc_pkg::MARK_W'(cfg_i.block_close), close_len);

    always_comb begin
        flags_o = flags_i;
        if (flags_i.skip != '0) begin
            flags_o.skip = flags_i.skip - 1'b1;
        end else if (flags_i.line_hit) begin
            flags_o = flags_i;
        end else if (flags_i.blk_active) begin
            if (close_hit) begin
                flags_o.blk_active = 1'b0;
                flags_o.skip       = close_len - 1'b1;
            end
        end else if (open_hit) begin
            flags_o.blk_active = 1'b1;
            flags_o.skip       = open_len - 1'b1;
        end else if (line_hit) begin
            flags_o.line_hit = 1'b1;
        end else if (!slc_pkg::is_space(window_i[7:0])) begin
            flags_o.saw_code = 1'b1;
        end
    end

    // Drop the head byte.
    assign window_o = window_i >> 8;
    assign fill_o   = fill_i - 1'b1;

endmodule

### hw/rtl/slc_line_counters.sv
// Per-file saturating counters of empty, comment and code lines.
// Depends on slc_pkg.
module slc_line_counters (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                bump_i,
    input  slc_pkg::kind_t      kind_i,
    input  logic                clear_i,
    output slc_pkg::counts_t    counts_next_o
);

    slc_pkg::counts_t counts_reg;

    function automatic logic [slc_pkg::COUNT_WIDTH-1:0] sat_inc(
        logic [slc_pkg::COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    always_comb begin
        counts_next_o = counts_reg;
        case (kind_i)
            slc_pkg::KIND_EMPTY:   counts_next_o.empty   = sat_inc(counts_reg.empty);
            slc_pkg::KIND_COMMENT: counts_next_o.comment = sat_inc(counts_reg.comment);
            slc_pkg::KIND_CODE:    counts_next_o.code    = sat_inc(counts_reg.code);
            default:               counts_next_o = counts_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg <= '0;
        end else if (bump_i) begin
            // Clear at end of file, after the last line has been reported.
            counts_reg <= clear_i ? '0 : counts_next_o;
        end
    end

endmodule

### hw/rtl/source_line_classifier.sv
// Source line classifier top level: byte stream in, one item per ended line out.
// Input stalls for a scan step when the 6-byte lookahead window is full, and from a
// line-ending byte until its result is handed over. After that byte is taken, the
// single shared scan unit scans out each of the 1 to 6 window bytes in S_DRAIN, then
// S_EMIT loads the result, waiting while an earlier result is still stalled.
// Reset (aresetn low, synchronous): registers to "//" 2 "/*" 2 "*/" 2, state cleared.
module source_line_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_byte
    input  logic                          s_tlast,   // last_in_file
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] line_kind, [33:2] empty_count, [65:34] comment_count,
    // [97:66] code_count, [103:98] zero
    output logic [slc_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,   // file_done
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slc_pkg::ADDR_W-1:0]    paddr,
    input  logic [slc_pkg::DATA_W-1:0]    pwdata,
    output logic [slc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        S_IDLE,   // take a byte
        S_SCAN,   // scan one head byte to free a window slot
        S_DRAIN,  // scan out the rest of the line
        S_EMIT    // classify the line and hand the result over
    } state_t;

    state_t                      state_reg, state_next;
    slc_pkg::cfg_t               cfg_reg, cfg_next;
    logic [slc_pkg::WIN_W-1:0]   window_reg, window_next;
    logic [slc_pkg::FILL_W-1:0]  fill_reg, fill_next;
    slc_pkg::scan_flags_t        flags_reg, flags_next;
    logic                        nonspace_reg, nonspace_next;
    logic                        line_open_reg, line_open_next;
    logic                        blk_start_reg, blk_start_next;
    logic                        last_reg, last_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [slc_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;

    logic [slc_pkg::WIN_W-1:0]   scan_window;
    logic [slc_pkg::FILL_W-1:0]  scan_fill;
    slc_pkg::scan_flags_t        scan_flags;
    slc_pkg::counts_t            counts_next;
    slc_pkg::kind_t              kind;
    logic                        s_fire;
    logic                        emit_fire;
    logic                        cfg_write;
    logic                        line_end;
    logic [2:0]                  reg_index;

    assign reg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign line_end  = s_tlast || (s_tdata == slc_pkg::NEWLINE);
    assign emit_fire = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // One marker test per cycle, shared by window-full scans and line drains.
    slc_scan_unit u_scan (
        .window_i (window_reg),
        .fill_i   (fill_reg),
        .flags_i  (flags_reg),
        .cfg_i    (cfg_reg),
        .window_o (scan_window),
        .fill_o   (scan_fill),
        .flags_o  (scan_flags)
    );

    slc_line_counters u_counters (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bump_i        (emit_fire),
        .kind_i        (kind),
        .clear_i       (last_reg),
        .counts_next_o (counts_next)
    );

    // Line kind from the state left after the drain.
    always_comb begin
        if (!nonspace_reg) begin
            kind = slc_pkg::KIND_EMPTY;
        end else if (flags_reg.blk_active) begin
            kind = slc_pkg::KIND_COMMENT;
        end else if (flags_reg.saw_code) begin
            kind = slc_pkg::KIND_CODE;
        end else begin
            kind = slc_pkg::KIND_COMMENT;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_index)
            slc_pkg::REG_LINE_MARKER:     prdata = slc_pkg::DATA_W'(cfg_reg.line_marker);
            slc_pkg::REG_LINE_MARKER_LEN: prdata = slc_pkg::DATA_W'(cfg_reg.line_marker_len);
            slc_pkg::REG_BLOCK_OPEN:      prdata = slc_pkg::DATA_W'(cfg_reg.block_open);
            slc_pkg::REG_BLOCK_OPEN_LEN:  prdata = slc_pkg::DATA_W'(cfg_reg.block_open_len);
            slc_pkg::REG_BLOCK_CLOSE:     prdata = slc_pkg::DATA_W'(cfg_reg.block_close);
            slc_pkg::REG_BLOCK_CLOSE_LEN: prdata = slc_pkg::DATA_W'(cfg_reg.block_close_len);
            default:                      prdata = '0;
        endcase
    end

    // Register writes; values are masked to the register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_index)
                slc_pkg::REG_LINE_MARKER:     cfg_next.line_marker     = pwdata[15:0];
                slc_pkg::REG_LINE_MARKER_LEN: cfg_next.line_marker_len = pwdata[1:0];
                slc_pkg::REG_BLOCK_OPEN:      cfg_next.block_open      = pwdata[47:0];
                slc_pkg::REG_BLOCK_OPEN_LEN:  cfg_next.block_open_len  = pwdata[2:0];
                slc_pkg::REG_BLOCK_CLOSE:     cfg_next.block_close     = pwdata[31:0];
                slc_pkg::REG_BLOCK_CLOSE_LEN: cfg_next.block_close_len = pwdata[2:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        flags_next     = flags_reg;
        nonspace_next  = nonspace_reg;
        line_open_next = line_open_reg;
        blk_start_next = blk_start_reg;
        last_next      = last_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    // Remember block state at the first byte of a line, so a
                    // blank line can restore it.
                    if (!line_open_reg) begin
                        line_open_next = 1'b1;
                        blk_start_next = flags_reg.blk_active;
                    end
                    if (!slc_pkg::is_space(s_tdata)) begin
                        nonspace_next = 1'b1;
                    end
                    // Append the byte at the tail of the window.
                    for (int i = 0; i < slc_pkg::MAX_MARKER_LEN; i++) begin
                        if (fill_reg == slc_pkg::FILL_W'(i)) begin
                            window_next[8*i +: 8] = s_tdata;
                        end
                    end
                    fill_next = fill_reg + 1'b1;
                    last_next = s_tlast;
                    if (line_end) begin
                        state_next = S_DRAIN;
                    end else if (fill_next == slc_pkg::FILL_W'(slc_pkg::MAX_MARKER_LEN)) begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                window_next = scan_window;
                fill_next   = scan_fill;
                flags_next  = scan_flags;
                state_next  = S_IDLE;
            end
            S_DRAIN: begin
                if (fill_reg != '0) begin
                    window_next = scan_window;
                    fill_next   = scan_fill;
                    flags_next  = scan_flags;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_reg;
                    m_tdata_next  = slc_pkg::OUT_W'({
                        slc_pkg::OUT_CNT_W'(counts_next.code),
                        slc_pkg::OUT_CNT_W'(counts_next.comment),
                        slc_pkg::OUT_CNT_W'(counts_next.empty),
                        kind});
                    // Blank lines leave the block state as it was at line start.
                    if (!nonspace_reg) begin
                        flags_next.blk_active = blk_start_reg;
                    end
                    // Clear line state; at end of file drop block state too.
                    window_next         = '0;
                    fill_next           = '0;
                    flags_next.skip     = '0;
                    flags_next.saw_code = 1'b0;
                    flags_next.line_hit = 1'b0;
                    nonspace_next       = 1'b0;
                    line_open_next      = 1'b0;
                    if (last_reg) begin
                        flags_next.blk_active = 1'b0;
                        blk_start_next        = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_reg       <= '{line_marker: 16'd12079, line_marker_len: 2'd2,
                               block_open: 48'd10799, block_open_len: 3'd2,
                               block_close: 32'd12074, block_close_len: 3'd2};
            window_reg    <= '0;
            fill_reg      <= '0;
            flags_reg     <= '0;
            nonspace_reg  <= 1'b0;
            line_open_reg <= 1'b0;
            blk_start_reg <= 1'b0;
            last_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            flags_reg     <= flags_next;
            nonspace_reg  <= nonspace_next;
            line_open_reg <= line_open_next;
            blk_start_reg <= blk_start_next;
            last_reg      <= last_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tlast_reg   <= m_tlast_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

### hw/rtl/slc_checker.sv
// Port-level checks of the source line classifier, bound to its top level.
// Depends on slc_pkg and source_line_classifier_defines.svh.
`include "source_line_classifier_defines.svh"

module slc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [7:0]                s_tdata,
    input logic                      s_tlast,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [slc_pkg::OUT_W-1:0] m_tdata
);

    // A stalled result holds its payload.
    `SLC_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A line-ending byte always starts a drain, so input stalls next cycle.
    `SLC_ASSERT_NEXT(a_drain_stall, s_tvalid && s_tready && (s_tlast || s_tdata == slc_pkg::NEWLINE), !s_tready, "byte taken during line drain")

    // Padding bits above the counters stay zero.
    `SLC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[slc_pkg::OUT_W-1:slc_pkg::OUT_BITS] == '0, "nonzero padding")

    // A fresh empty-line result has counted itself.
    `SLC_ASSERT_NOW(a_empty_counted, $rose(m_tvalid) && m_tdata[1:0] == slc_pkg::KIND_EMPTY, m_tdata[33:2] != '0, "empty line not counted")

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);

### tb/tb.sv
// Self-checking testbench for source_line_classifier: streams file bytes in,
// predicts each line's kind and per-file tallies, and checks every line result.
// Depends on slc_pkg (types, register indexes, widths) and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 500000;
    localparam int unsigned ITEMS_PER_STEP = 175;
    localparam int unsigned SETTLE_CYCLES  = 16;

    // One item of the input stream: a byte and the end-of-file flag.
    typedef struct packed {
        logic       eof;
        logic [7:0] c;
    } stream_item_t;

    // Expected contents of one line result.
    typedef struct packed {
        slc_pkg::kind_t kind;
        logic [31:0]    empties;
        logic [31:0]    comments;
        logic [31:0]    codes;
        logic           file_done;
    } line_result_t;

    // Line classifier scoreboard: carries its own copy of the registers and the
    // scan state, turns every accepted byte into zero or one expected line
    // result, and checks the results in order.
    class line_scoreboard;
        slc_pkg::cfg_t                   cfg;
        logic [7:0]                      lookahead [slc_pkg::MAX_MARKER_LEN];
        int unsigned                     fill;
        int unsigned                     skip;
        bit                              block_active;
        bit                              saw_code;
        bit                              comment_hit;
        bit                              nonspace;
        bit                              line_open;
        bit                              block_at_start;
        logic [slc_pkg::COUNT_WIDTH-1:0] tally [3];
        line_result_t                    expected_lines [$];
        int unsigned                     mismatches;

        function new();
            cfg.line_marker     = 16'h2f2f;
            cfg.line_marker_len = 2'd2;
            cfg.block_open      = 48'h2a2f;
            cfg.block_open_len  = 3'd2;
            cfg.block_close     = 32'h2f2a;
            cfg.block_close_len = 3'd2;
            clear_line();
            block_active   = 1'b0;
            block_at_start = 1'b0;
            foreach (tally[i]) tally[i] = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                slc_pkg::REG_LINE_MARKER:     cfg.line_marker     = v[15:0];
                slc_pkg::REG_LINE_MARKER_LEN: cfg.line_marker_len = v[1:0];
                slc_pkg::REG_BLOCK_OPEN:      cfg.block_open      = v[47:0];
                slc_pkg::REG_BLOCK_OPEN_LEN:  cfg.block_open_len  = v[2:0];
                slc_pkg::REG_BLOCK_CLOSE:     cfg.block_close     = v[31:0];
                slc_pkg::REG_BLOCK_CLOSE_LEN: cfg.block_close_len = v[2:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function bit is_ws(logic [7:0] c);
            return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
        endfunction

        // Clamp a length to the bytes its register holds and to the window.
        function int unsigned clamp_len(logic [2:0] raw, int unsigned cap);
            int unsigned n;
            n = 32'(raw);
            if (n > cap) n = cap;
            if (n > slc_pkg::MAX_MARKER_LEN) n = slc_pkg::MAX_MARKER_LEN;
            return n;
        endfunction

        function bit head_matches(logic [63:0] pattern, int unsigned n);
            if (n == 0 || n > fill) return 1'b0;
            for (int k = 0; k < n; k++)
                if (lookahead[k] != pattern[8*k +: 8]) return 1'b0;
            return 1'b1;
        endfunction

        // Scan the oldest window byte, then drop it from the window.
        function void advance_head();
            int unsigned n_open;
            int unsigned n_line;
            int unsigned n_close;
            if (fill == 0) return;
            n_open  = clamp_len(cfg.block_open_len, 6);
            n_line  = clamp_len({1'b0, cfg.line_marker_len}, 2);
            n_close = clamp_len(cfg.block_close_len, 4);
            if (skip > 0) begin
                skip--;
            end else if (comment_hit) begin
                // rest of the line is comment text
            end else if (block_active) begin
                if (head_matches(64'(cfg.block_close), n_close)) begin
                    block_active = 1'b0;
                    skip = n_close - 1;
                end
            end else if (head_matches(64'(cfg.block_open), n_open)) begin
                block_active = 1'b1;
                skip = n_open - 1;
            end else if (head_matches(64'(cfg.line_marker), n_line)) begin
                comment_hit = 1'b1;
            end else if (!is_ws(lookahead[0])) begin
                saw_code = 1'b1;
            end
            for (int k = 0; k < slc_pkg::MAX_MARKER_LEN - 1; k++)
                lookahead[k] = lookahead[k+1];
            fill--;
        endfunction

        function void clear_line();
            foreach (lookahead[i]) lookahead[i] = '0;
            fill        = 0;
            skip        = 0;
            saw_code    = 1'b0;
            comment_hit = 1'b0;
            nonspace    = 1'b0;
            line_open   = 1'b0;
        endfunction

        // Note one accepted byte; a line-ending byte queues one expected result.
        function void note_byte(logic [7:0] c, logic eof);
            bit             ends;
            slc_pkg::kind_t kind;
            line_result_t   r;
            ends = eof || (c == slc_pkg::NEWLINE);
            if (!line_open) begin
                line_open      = 1'b1;
                block_at_start = block_active;
            end
            if (!is_ws(c)) nonspace = 1'b1;
            if (fill >= slc_pkg::MAX_MARKER_LEN) advance_head();
            lookahead[fill] = c;
            fill++;
            if (!ends) begin
                if (fill >= slc_pkg::MAX_MARKER_LEN) advance_head();
                return;
            end
            while (fill > 0) advance_head();

            // A blank line leaves the block state as it was at line start.
            if (!nonspace) begin
                kind         = slc_pkg::KIND_EMPTY;
                block_active = block_at_start;
            end else if (block_active) begin
                kind = slc_pkg::KIND_COMMENT;
            end else begin
                kind = saw_code ? slc_pkg::KIND_CODE : slc_pkg::KIND_COMMENT;
            end
            if (tally[kind] != {slc_pkg::COUNT_WIDTH{1'b1}}) tally[kind]++;

            r.kind      = kind;
            r.empties   = tally[slc_pkg::KIND_EMPTY][31:0];
            r.comments  = tally[slc_pkg::KIND_COMMENT][31:0];
            r.codes     = tally[slc_pkg::KIND_CODE][31:0];
            r.file_done = eof;
            expected_lines.push_back(r);

            clear_line();
            if (eof) begin
                block_active   = 1'b0;
                block_at_start = 1'b0;
                foreach (tally[i]) tally[i] = '0;
            end
        endfunction

        function void check_line(logic [slc_pkg::OUT_W-1:0] data, logic done);
            line_result_t want;
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"tb: line result with none expected:",
                              " kind=%0d e=%0d c=%0d k=%0d done=%0b"},
                             data[1:0], data[33:2], data[65:34], data[97:66], done);
                return;
            end
            want = expected_lines.pop_front();
            if (data[1:0] != want.kind || data[33:2] != want.empties ||
                data[65:34] != want.comments || data[97:66] != want.codes ||
                done != want.file_done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"tb: line mismatch: expected kind=%0d e=%0d c=%0d k=%0d done=%0b,",
                              " got kind=%0d e=%0d c=%0d k=%0d done=%0b"},
                             want.kind, want.empties, want.comments, want.codes,
                             want.file_done, data[1:0], data[33:2], data[65:34],
                             data[97:66], done);
            end
        endfunction
    endclass

    // Clock, reset and block ports; every input starts at a known value.
    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;   // [7:0] char_byte
    logic                          s_tlast  = 1'b0; // last_in_file
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [1:0] line_kind, [33:2] empty_count, [65:34] comment_count,
    // [97:66] code_count, [103:98] zero
    logic [slc_pkg::OUT_W-1:0]     m_tdata;
    logic                          m_tlast;         // file_done
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [slc_pkg::ADDR_W-1:0]    paddr    = '0;
    logic [slc_pkg::DATA_W-1:0]    pwdata   = '0;
    logic [slc_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    line_scoreboard       sb = new();
    stream_item_t         file_items [$];
    int unsigned          cycles     = 0;
    int unsigned          items_sent = 0;
    int unsigned          stall_tick = 0;
    int unsigned          stall_mode = 0;

    source_line_classifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Hard stop: a hung handshake must not stall the run forever.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Monitor both channels at the rising edge. A result always belongs to
    // bytes taken at earlier edges, so the order of the two calls is free.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_line(m_tdata, m_tlast);
    end

    // Receiver back-pressure: switch at random between always ready, coin flips, heavy
    // stalls and a slow square wave.
    always @(negedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 96) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_tick[2];
        endcase
    end

    // Write one register: setup cycle, then access cycle; the write lands at
    // the edge where psel, penable, pwrite and pready are all high.
    task automatic apb_write(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(logic [63:0] lm, logic [63:0] lm_len, logic [63:0] bo,
                               logic [63:0] bo_len, logic [63:0] bc, logic [63:0] bc_len);
        apb_write(slc_pkg::REG_LINE_MARKER, lm);
        apb_write(slc_pkg::REG_LINE_MARKER_LEN, lm_len);
        apb_write(slc_pkg::REG_BLOCK_OPEN, bo);
        apb_write(slc_pkg::REG_BLOCK_OPEN_LEN, bo_len);
        apb_write(slc_pkg::REG_BLOCK_CLOSE, bc);
        apb_write(slc_pkg::REG_BLOCK_CLOSE_LEN, bc_len);
    endtask

    // Present one item and hold it until the block takes it. Enter and leave
    // at a falling edge; tvalid stays high so back-to-back items stream.
    task automatic send_item(stream_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= it.c;
        s_tlast  <= it.eof;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stream the built file in bursts with random gaps between them. With
    // hold_mid set, stop halfway until every queued line result has come.
    task automatic send_items(bit hold_mid);
        int unsigned burst_left;
        bit          gaps_on;
        burst_left = 0;
        gaps_on    = ($urandom_range(0, 3) != 0);
        foreach (file_items[i]) begin
            if (hold_mid && i == file_items.size() / 2) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (sb.pending() != 0) @(negedge aclk);
            end
            if (gaps_on && burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = $urandom_range(1, 30);
            end
            send_item(file_items[i]);
            if (burst_left > 0) burst_left--;
        end
        items_sent += file_items.size();
    endtask

    // Idle the input and let every outstanding line result come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic push_byte(logic [7:0] c);
        file_items.push_back({1'b0, c});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Append one token: a marker of the current setting, a partial marker,
    // whitespace, printable code or a raw byte of any value.
    task automatic add_token();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            n = sb.cfg.line_marker_len;
            if (n == 0 || n > 2) n = 2;
            for (int k = 0; k < n; k++) push_byte(sb.cfg.line_marker[8*k +: 8]);
        end else if (pick < 28) begin
            n = sb.cfg.block_open_len;
            if (n == 0) n = $urandom_range(1, 6);
            if (n > 6) n = 6;
            for (int k = 0; k < n; k++) push_byte(sb.cfg.block_open[8*k +: 8]);
        end else if (pick < 42) begin
            n = sb.cfg.block_close_len;
            if (n == 0) n = $urandom_range(1, 4);
            if (n > 4) n = 4;
            for (int k = 0; k < n; k++) push_byte(sb.cfg.block_close[8*k +: 8]);
        end else if (pick < 48) begin
            push_byte(sb.cfg.block_open[7:0]);
        end else if (pick < 65) begin
            case ($urandom_range(0, 4))
                0: push_byte(8'h09);
                1: push_byte(8'h0b);
                2: push_byte(8'h0c);
                3: push_byte(8'h0d);
                default: push_byte(8'h20);
            endcase
        end else if (pick < 88) begin
            push_byte(8'($urandom_range(33, 126)));
        end else begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Build a file of newline-ended lines; the final line either ends on its
    // newline or on one more byte that carries the end-of-file flag.
    task automatic build_file();
        stream_item_t tail;
        file_items.delete();
        repeat ($urandom_range(1, 8)) begin
            repeat ($urandom_range(0, 6)) add_token();
            push_byte(slc_pkg::NEWLINE);
        end
        if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 255)));
        tail = file_items.pop_back();
        tail.eof = 1'b1;
        file_items.push_back(tail);
    endtask

    // Pick a marker byte from a small alphabet so that markers overlap.
    function automatic logic [7:0] mark_byte();
        case ($urandom_range(0, 5))
            0: return 8'h2f;
            1: return 8'h2a;
            2: return 8'h23;
            3: return 8'h2d;
            4: return 8'h3b;
            default: return 8'h7b;
        endcase
    endfunction

    // Register setting for each step of the run.
    task automatic configure(int unsigned step);
        logic [63:0] lm;
        logic [63:0] bo;
        logic [63:0] bc;
        lm = '0;
        bo = '0;
        bc = '0;
        case (step)
            1: begin
                // longest markers the registers hold
                for (int k = 0; k < 2; k++) lm[8*k +: 8] = mark_byte();
                for (int k = 0; k < 6; k++) bo[8*k +: 8] = mark_byte();
                for (int k = 0; k < 4; k++) bc[8*k +: 8] = mark_byte();
                load_config(lm, 64'd2, bo, 64'd6, bc, 64'd4);
            end
            2: load_config('0, 64'd0, '0, 64'd0, '0, 64'd0);   // no markers at all
            3: load_config('1, 64'd3, '1, 64'd7, '1, 64'd7);   // lengths past the caps clamp
            4: begin
                // whitespace block opener that never closes
                load_config(64'h23, 64'd1, 64'h0920, 64'd2, 64'h2f2a, 64'd0);
            end
            5: begin
                // random values with junk above each field's width
                lm = {$urandom, $urandom};
                bo = {$urandom, $urandom};
                bc = {$urandom, $urandom};
                for (int k = 0; k < 6; k++)
                    if ($urandom_range(0, 1) != 0) bo[8*k +: 8] = mark_byte();
                load_config(lm, 64'($urandom_range(0, 3)), bo, 64'($urandom_range(0, 7)),
                            bc, 64'($urandom_range(0, 7)));
            end
            6: load_config(64'h23, 64'd1, 64'h7b, 64'd1, 64'h7d, 64'd1);   // one-byte markers
            7: load_config(64'h2f2f, 64'd2, 64'h2a2f, 64'd2, 64'h2f2a, 64'd2);
            default: ;   // step 0 runs on the reset setting
        endcase
    endtask

    initial begin
        int unsigned step_start;

        // Hold reset, then release it at a falling edge.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed lines on the reset setting: bare newline, block open, a
        // blank line inside the block, close then code, code before a line
        // comment, a pure line comment, then NUL and 0xff ending the file
        // without a newline.
        file_items.delete();
        push_text("\n");
        push_text("/*\n");
        push_text(" \n");
        push_text("a*/b\n");
        push_text("x//\n");
        push_text("//y\n");
        push_byte(8'h00);
        file_items.push_back({1'b1, 8'hff});
        send_items(1'b0);
        drain();

        for (int unsigned step = 0; step < 8; step++) begin
            configure(step);
            step_start = items_sent;
            // The first file of each step holds halfway until the block is empty.
            build_file();
            send_items(1'b1);
            while (items_sent - step_start < ITEMS_PER_STEP) begin
                build_file();
                send_items(1'b0);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
